/* hw/rtl/emcal_pkg.sv */
// Package for the millisecond timestamp to calendar field converter.
// Holds widths, reciprocal constants, month tables and the year-start function.
// No dependencies; imported by epoch_ms_to_calendar_fields and its testbench.
`default_nettype none

package emcal_pkg;

  // Field widths of the streams.
  localparam int unsigned EPOCH_W    = 42;
  localparam int unsigned YEAR_W     = 12;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MINUTE_W   = 6;
  localparam int unsigned SECOND_W   = 6;
  localparam int unsigned MILLI_W    = 10;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  // Internal widths.
  localparam int unsigned DAYS_W    = 16;
  localparam int unsigned DOY_W     = 9;
  localparam int unsigned IDX_RAW_W = 8;

  // Calendar constants.
  localparam int unsigned FIRST_YEAR    = 1970;
  localparam int unsigned DAYS_COMMON   = 365;
  localparam int unsigned MONTHS        = 12;
  localparam int unsigned YEAR_SPAN_DEF = 131;

  // Reciprocals for exact division by constants: q = (x * RCP) >> SH.
  // Milliseconds to seconds: (t >> 3) / 125 on a 39-bit value.
  localparam int unsigned SH_SEC  = 46;
  localparam logic [63:0] RCP_SEC_W = ((64'd1 << SH_SEC) + 64'd124) / 64'd125;
  localparam logic [39:0] RCP_SEC = RCP_SEC_W[39:0];
  // Seconds to minutes: (s >> 2) / 15 on a 31-bit value.
  localparam int unsigned SH_MIN  = 35;
  localparam logic [63:0] RCP_MIN_W = ((64'd1 << SH_MIN) + 64'd14) / 64'd15;
  localparam logic [31:0] RCP_MIN = RCP_MIN_W[31:0];
  // Minutes to hours: (m >> 2) / 15 on a 25-bit value.
  localparam int unsigned SH_HR   = 29;
  localparam logic [63:0] RCP_HR_W = ((64'd1 << SH_HR) + 64'd14) / 64'd15;
  localparam logic [25:0] RCP_HR = RCP_HR_W[25:0];
  // Hours to days: (h >> 3) / 3 on an 18-bit value.
  localparam int unsigned SH_DAY  = 20;
  localparam logic [63:0] RCP_DAY_W = ((64'd1 << SH_DAY) + 64'd2) / 64'd3;
  localparam logic [18:0] RCP_DAY = RCP_DAY_W[18:0];
  // Days to a year guess: d / 365 on a 16-bit value.
  localparam int unsigned SH_YR   = 25;
  localparam logic [63:0] RCP_YR_W = ((64'd1 << SH_YR) + 64'd364) / 64'd365;
  localparam logic [16:0] RCP_YR = RCP_YR_W[16:0];

  // Cumulative day counts at the start of each month.
  localparam logic [DOY_W-1:0] MONTH_START_COMMON [MONTHS+1] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
  localparam logic [DOY_W-1:0] MONTH_START_LEAP [MONTHS+1] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

  // Time of day as it travels down the pipeline.
  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [MILLI_W-1:0]  millisecond;
  } tod_t;

  // Gregorian leap-year rule.
  function automatic logic is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Leap days in the years up to and including y.
  function automatic int unsigned leaps_through(input int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // Days from the epoch to 1 January of year FIRST_YEAR + idx.
  // Only evaluated on constants while building tables.
  function automatic logic [DAYS_W-1:0] year_start(input int unsigned idx);
    int unsigned y;
    int unsigned d;
    y = FIRST_YEAR + idx;
    d = DAYS_COMMON * idx + leaps_through(y - 1) - leaps_through(FIRST_YEAR - 1);
    return DAYS_W'(d);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/epoch_ms_to_calendar_fields.sv */
// Top level of the millisecond timestamp to calendar field converter.
// Ten-stage pipeline built from constant reciprocal multiplies and table look-ups.
// Depends on emcal_pkg.
//
//   Channel   Direction  Payload                                         Accepted when
//   s_axis    in         tdata: epoch_millis                             s_axis_tvalid & s_axis_tready
//   m_axis    out        tdata: calendar fields, tuser: in_range          m_axis_tvalid & m_axis_tready
//
// One transaction enters per clock unless back-pressure holds the pipeline; each result
// passes through the ten register stages of the divide and look-up chain.
// The synchronous reset empties every stage; payload registers are not reset.
// Each stage holds only while it is full and the stage after it cannot take its
// contents, so bubbles close up and input is taken while a result waits, if any stage is empty.
`default_nettype none

module epoch_ms_to_calendar_fields
  import emcal_pkg::*;
#(
  parameter int unsigned YEAR_SPAN = YEAR_SPAN_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Fields from bit 0: epoch_millis[41:0], zero fill [47:42].
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // Fields from bit 0: year[11:0], month[15:12], day[20:16], hour[25:21],
  // minute[31:26], second[37:32], millisecond[47:38].
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // Fields from bit 0: in_range[0].
  output logic                        m_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready
);

  localparam int unsigned NUM_ST = 10;
  localparam int unsigned IDX_W  = (YEAR_SPAN > 1) ? $clog2(YEAR_SPAN + 1) : 1;
  localparam logic [DAYS_W-1:0] DAY_LIMIT = year_start(YEAR_SPAN);

  // Year tables built at elaboration.
  logic [DAYS_W-1:0] year_tab [YEAR_SPAN+1];
  logic [YEAR_SPAN:0] leap_tab;

  for (genvar g = 0; g <= YEAR_SPAN; g++) begin : g_year_tab
    assign year_tab[g] = year_start(g);
    assign leap_tab[g] = is_leap(FIRST_YEAR + g);
  end

  // Stage occupancy and load enables.
  logic [NUM_ST-1:0] vld;
  logic [NUM_ST-1:0] en;

  always_comb begin
    en[NUM_ST-1] = !vld[NUM_ST-1] || m_axis_tready;
    for (int k = NUM_ST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_ST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: partial products of (t >> 3) times the reciprocal of 125.
  logic [38:0] ms_q;
  logic [39:0] pp_ll, pp_lh;
  logic [38:0] pp_hl, pp_hh;
  logic [9:0]  tlo1;

  assign ms_q = s_axis_tdata[EPOCH_W-1:3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_ll <= ms_q[19:0]  * RCP_SEC[19:0];
      pp_lh <= ms_q[19:0]  * RCP_SEC[39:20];
      pp_hl <= ms_q[38:20] * RCP_SEC[19:0];
      pp_hh <= ms_q[38:20] * RCP_SEC[39:20];
      tlo1  <= s_axis_tdata[9:0];
    end
  end

  // Stage 2: sum the partial products to get whole seconds.
  logic [59:0] sec_sum;
  logic [32:0] secs2;
  logic [9:0]  tlo2;

  assign sec_sum = 60'({pp_hh, 20'd0}) + 60'(pp_lh) + 60'(pp_hl) + 60'(pp_ll[39:20]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      secs2 <= sec_sum[SH_SEC-20+32:SH_SEC-20];
      tlo2  <= tlo1;
    end
  end

  // Stage 3: millisecond remainder and the multiply towards minutes.
  logic [9:0]  ms_sub;
  logic [9:0]  ms3;
  logic [5:0]  slo3;
  logic [62:0] prod2_3;

  assign ms_sub = 10'(secs2[9:0] * 10'd1000);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ms3     <= tlo2 - ms_sub;
      slo3    <= secs2[5:0];
      prod2_3 <= secs2[32:2] * RCP_MIN;
    end
  end

  // Stage 4: second remainder and the multiply towards hours.
  logic [26:0] mins4;
  logic [5:0]  sec_sub;
  logic [9:0]  ms4;
  logic [5:0]  sec4;
  logic [5:0]  mlo4;
  logic [50:0] prod3_4;

  assign mins4   = prod2_3[SH_MIN+26:SH_MIN];
  assign sec_sub = 6'(mins4[5:0] * 6'd60);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ms4     <= ms3;
      sec4    <= slo3 - sec_sub;
      mlo4    <= mins4[5:0];
      prod3_4 <= mins4[26:2] * RCP_HR;
    end
  end

  // Stage 5: minute remainder and the multiply towards days.
  logic [20:0] hrs5;
  logic [5:0]  min_sub;
  logic [9:0]  ms5;
  logic [5:0]  sec5;
  logic [5:0]  min5;
  logic [4:0]  hlo5;
  logic [36:0] prod4_5;

  assign hrs5    = prod3_4[SH_HR+20:SH_HR];
  assign min_sub = 6'(hrs5[5:0] * 6'd60);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ms5     <= ms4;
      sec5    <= sec4;
      min5    <= mlo4 - min_sub;
      hlo5    <= hrs5[4:0];
      prod4_5 <= hrs5[20:3] * RCP_DAY;
    end
  end

  // Stage 6: hour remainder, range check and the multiply for the year guess.
  logic [DAYS_W-1:0] days_c;
  logic [4:0]        hr_sub;
  tod_t              tod6;
  logic              ok6;
  logic [DAYS_W-1:0] days6;
  logic [32:0]       prod5_6;

  assign days_c = prod4_5[SH_DAY+DAYS_W-1:SH_DAY];
  assign hr_sub = 5'(days_c[4:0] * 5'd24);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      tod6.hour        <= hlo5 - hr_sub;
      tod6.minute      <= min5;
      tod6.second      <= sec5;
      tod6.millisecond <= ms5;
      ok6              <= days_c < DAY_LIMIT;
      days6            <= days_c;
      prod5_6          <= days_c * RCP_YR;
    end
  end

  // Stage 7: year guess, moved back by one when the day falls before its start.
  logic [IDX_RAW_W-1:0] idx_raw;
  logic [IDX_W-1:0]     idx_clamp;
  logic [IDX_W-1:0]     idx_fix;
  tod_t                 tod7;
  logic                 ok7;
  logic [DAYS_W-1:0]    days7;
  logic [IDX_W-1:0]     idx7;

  assign idx_raw = prod5_6[SH_YR+IDX_RAW_W-1:SH_YR];

  always_comb begin
    if (idx_raw > IDX_RAW_W'(YEAR_SPAN)) begin
      idx_clamp = IDX_W'(YEAR_SPAN);
    end else begin
      idx_clamp = IDX_W'(idx_raw);
    end
    if ((idx_clamp != '0) && (days6 < year_tab[idx_clamp])) begin
      idx_fix = IDX_W'(idx_clamp - 1'b1);
    end else begin
      idx_fix = idx_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      tod7  <= tod6;
      ok7   <= ok6;
      days7 <= days6;
      idx7  <= idx_fix;
    end
  end

  // Stage 8: day of the year and the leap flag of that year.
  tod_t             tod8;
  logic             ok8;
  logic [IDX_W-1:0] idx8;
  logic [DOY_W-1:0] doy8;
  logic             leap8;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      tod8  <= tod7;
      ok8   <= ok7;
      idx8  <= idx7;
      doy8  <= DOY_W'(days7 - year_tab[idx7]);
      leap8 <= leap_tab[idx7];
    end
  end

  // Stage 9: month from the count of month starts already passed.
  logic [MONTH_W-1:0] month_c;
  tod_t               tod9;
  logic               ok9;
  logic [IDX_W-1:0]   idx9;
  logic [DOY_W-1:0]   doy9;
  logic               leap9;
  logic [MONTH_W-1:0] month9;

  always_comb begin
    month_c = MONTH_W'(1);
    for (int k = 1; k < MONTHS; k++) begin
      if (doy8 >= (leap8 ? MONTH_START_LEAP[k] : MONTH_START_COMMON[k])) begin
        month_c = MONTH_W'(month_c + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      tod9   <= tod8;
      ok9    <= ok8;
      idx9   <= idx8;
      doy9   <= doy8;
      leap9  <= leap8;
      month9 <= month_c;
    end
  end

  // Stage 10: day of the month and the output register; out of range gives zeros.
  logic [MONTH_W-1:0] mon_idx;
  logic [DOY_W-1:0]   mon_start;
  logic [DAY_W-1:0]   day_c;
  logic [YEAR_W-1:0]  res_year;
  logic [MONTH_W-1:0] res_month;
  logic [DAY_W-1:0]   res_day;
  tod_t               res_tod;
  logic               res_ok;

  assign mon_idx   = MONTH_W'(month9 - 1'b1);
  assign mon_start = leap9 ? MONTH_START_LEAP[mon_idx] : MONTH_START_COMMON[mon_idx];
  assign day_c     = DAY_W'(doy9 - mon_start + 9'd1);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      res_ok <= ok9;
      if (ok9) begin
        res_year  <= YEAR_W'(FIRST_YEAR) + YEAR_W'(idx9);
        res_month <= month9;
        res_day   <= day_c;
        res_tod   <= tod9;
      end else begin
        res_year  <= '0;
        res_month <= '0;
        res_day   <= '0;
        res_tod   <= '0;
      end
    end
  end

  // Output stream.
  assign m_axis_tvalid = vld[NUM_ST-1];
  assign m_axis_tuser  = res_ok;
  assign m_axis_tdata  = {res_tod.millisecond, res_tod.second, res_tod.minute,
                          res_tod.hour, res_day, res_month, res_year};

endmodule

`default_nettype wire

/* dv/epoch_ms_to_calendar_fields_tb.sv */
// Self-checking testbench for epoch_ms_to_calendar_fields.
// Checks every result transaction against an in-bench calendar conversion.
// Stalls and gaps are random on both streams. Depends on emcal_pkg and the block RTL.
`default_nettype none

module epoch_ms_to_calendar_fields_tb;
  import emcal_pkg::*;

  localparam int unsigned SPAN_YEARS    = YEAR_SPAN_DEF;
  localparam longint unsigned MS_PER_DAY = 64'd86400000;
  localparam int unsigned PIPE_DRAIN    = 40;
  localparam int unsigned RANDOM_ITEMS  = 1080;
  localparam longint unsigned RUN_LIMIT = 64'd6000000;

  // Calendar fields of one result transaction.
  typedef struct packed {
    logic                in_range;
    logic [MILLI_W-1:0]  millisecond;
    logic [SECOND_W-1:0] second;
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
  } cal_fields_t;

  // Days before the first of each month.
  localparam int unsigned CUM_COMMON [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                              304, 334, 365};
  localparam int unsigned CUM_LEAP [13]   = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274,
                                              305, 335, 366};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;

  logic [EPOCH_W-1:0] pending_stamps [$];
  cal_fields_t        expected_dates [$];

  int unsigned error_count = 0;
  int unsigned converted_count = 0;
  int unsigned beyond_span_count = 0;
  int unsigned leap_day_count = 0;
  int unsigned send_idle = 0;
  int unsigned send_quiet = 0;
  int unsigned recv_stall = 0;
  int unsigned recv_quiet = 0;

  epoch_ms_to_calendar_fields DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #6 clk = ~clk;

  // Gregorian leap rule.
  function automatic bit gregorian_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Days from the epoch to 1 January of the year yi years after 1970.
  function automatic int unsigned days_to_jan1(input int unsigned yi);
    int unsigned total;
    total = 0;
    for (int unsigned k = 0; k < yi; k++) begin
      total += gregorian_leap(FIRST_YEAR + k) ? 366 : 365;
    end
    return total;
  endfunction

  // Expected calendar fields for one timestamp.
  function automatic cal_fields_t convert_millis(input logic [EPOCH_W-1:0] stamp);
    longint unsigned t;
    int unsigned     d;
    int unsigned     yi;
    int unsigned     doy;
    int unsigned     m;
    bit              leap;
    cal_fields_t     r;
    r = '0;
    t = 64'(stamp);
    r.millisecond = MILLI_W'(t % 1000);
    t = t / 1000;
    r.second = SECOND_W'(t % 60);
    t = t / 60;
    r.minute = MINUTE_W'(t % 60);
    t = t / 60;
    r.hour = HOUR_W'(t % 24);
    t = t / 24;
    if (t >= days_to_jan1(SPAN_YEARS)) begin
      return '0;
    end
    d  = int'(t);
    yi = d / DAYS_COMMON;
    if (yi > 0 && d < days_to_jan1(yi)) begin
      yi--;
    end
    doy  = d - days_to_jan1(yi);
    leap = gregorian_leap(FIRST_YEAR + yi);
    m = 1;
    while (m < MONTHS && doy >= (leap ? CUM_LEAP[m] : CUM_COMMON[m])) begin
      m++;
    end
    r.year     = YEAR_W'(FIRST_YEAR + yi);
    r.month    = MONTH_W'(m);
    r.day      = DAY_W'(doy - (leap ? CUM_LEAP[m-1] : CUM_COMMON[m-1]) + 1);
    r.in_range = 1'b1;
    return r;
  endfunction

  // Timestamp for a given year offset, day of year and time of day.
  function automatic logic [EPOCH_W-1:0] stamp_of(input int unsigned yi, input int unsigned doy,
                                                  input int unsigned h, input int unsigned mi,
                                                  input int unsigned s, input int unsigned ms);
    longint unsigned days;
    days = 64'(days_to_jan1(yi) + doy);
    return EPOCH_W'((((days * 24 + h) * 60 + mi) * 60 + s) * 1000 + ms);
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned draw_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic string show_fields(input cal_fields_t f);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d.%0d in_range=%0b", f.year, f.month, f.day,
                     f.hour, f.minute, f.second, f.millisecond, f.in_range);
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Reset, then release.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Input driver: presents queued timestamps with random gaps between transactions.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_dates.push_back(convert_millis(s_axis_tdata[EPOCH_W-1:0]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_idle > 0) begin
          send_idle--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_stamps.size() > 0) begin
          s_axis_tdata  <= {{(IN_TDATA_W-EPOCH_W){1'b0}}, pending_stamps.pop_front()};
          s_axis_tvalid <= 1'b1;
          if (send_quiet > 0) begin
            send_quiet--;
          end else if ($urandom_range(0, 99) < 3) begin
            send_quiet = $urandom_range(20, 80);
          end
          send_idle = (send_quiet > 0) ? 0 : draw_idle();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random back-pressure, and a field check on every accepted transaction.
  always @(posedge clk) begin
    cal_fields_t got;
    cal_fields_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.year        = m_axis_tdata[11:0];
        got.month       = m_axis_tdata[15:12];
        got.day         = m_axis_tdata[20:16];
        got.hour        = m_axis_tdata[25:21];
        got.minute      = m_axis_tdata[31:26];
        got.second      = m_axis_tdata[37:32];
        got.millisecond = m_axis_tdata[47:38];
        got.in_range    = m_axis_tuser;
        if (expected_dates.size() == 0) begin
          note_failure($sformatf("unexpected result transaction: %s", show_fields(got)));
        end else begin
          want = expected_dates.pop_front();
          converted_count++;
          if (!want.in_range) beyond_span_count++;
          if (want.in_range && want.month == 2 && want.day == 29) leap_day_count++;
          if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
              got.hour !== want.hour || got.minute !== want.minute ||
              got.second !== want.second || got.millisecond !== want.millisecond ||
              got.in_range !== want.in_range) begin
            note_failure($sformatf("result %0d: expected %s, got %s", converted_count,
                                   show_fields(want), show_fields(got)));
          end
        end
      end
      if (recv_quiet > 0) begin
        recv_quiet--;
      end else if ($urandom_range(0, 199) == 0) begin
        recv_quiet = $urandom_range(30, 120);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else if (recv_quiet == 0 && $urandom_range(0, 99) < 30) begin
        recv_stall = draw_idle();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    longint unsigned span_ms;
    longint signed   pick;
    int unsigned     yi;
    int unsigned     r;
    span_ms = longint'(days_to_jan1(SPAN_YEARS)) * MS_PER_DAY;

    // Directed: field extremes, the end of the covered span, leap days and year corrections.
    pending_stamps.push_back('0);
    pending_stamps.push_back({EPOCH_W{1'b1}});
    pending_stamps.push_back(EPOCH_W'(span_ms - 1));
    pending_stamps.push_back(EPOCH_W'(span_ms));
    pending_stamps.push_back(stamp_of(2, 59, 12, 0, 0, 0));
    pending_stamps.push_back(stamp_of(2, 60, 0, 0, 0, 0));
    pending_stamps.push_back(stamp_of(2, 365, 23, 59, 59, 999));
    pending_stamps.push_back(stamp_of(29, 364, 23, 59, 59, 999));
    pending_stamps.push_back(stamp_of(30, 0, 0, 0, 0, 0));
    pending_stamps.push_back(stamp_of(30, 59, 6, 30, 15, 500));
    pending_stamps.push_back(stamp_of(30, 365, 23, 59, 59, 999));
    pending_stamps.push_back(stamp_of(129, 364, 23, 59, 59, 999));
    pending_stamps.push_back(stamp_of(130, 58, 1, 2, 3, 4));
    pending_stamps.push_back(stamp_of(130, 59, 0, 0, 0, 0));
    // The first of every month in a common year.
    for (int unsigned mo = 0; mo < 12; mo++) begin
      pending_stamps.push_back(stamp_of(53, CUM_COMMON[mo], mo, mo * 5, mo * 4, mo * 83));
    end

    // Random: mostly instants inside the span, some near New Year, some over the whole field.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        pending_stamps.push_back(EPOCH_W'({$urandom_range(0, 1023), $urandom()}));
      end else if (r < 35) begin
        yi   = $urandom_range(0, SPAN_YEARS);
        pick = longint'(days_to_jan1(yi)) * longint'(MS_PER_DAY)
               + longint'($urandom_range(0, 4 * 86400)) * 1000 + $urandom_range(0, 999)
               - 2 * longint'(MS_PER_DAY);
        if (pick < 0) pick = longint'($urandom_range(0, 999));
        pending_stamps.push_back(EPOCH_W'(pick));
      end else begin
        pick = longint'($urandom_range(0, days_to_jan1(SPAN_YEARS) - 1)) * longint'(MS_PER_DAY)
               + longint'($urandom_range(0, 86399)) * 1000 + $urandom_range(0, 999);
        pending_stamps.push_back(EPOCH_W'(pick));
      end
    end

    @(negedge rst);
    while (pending_stamps.size() > 0 || s_axis_tvalid || expected_dates.size() > 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DRAIN) @(posedge clk);
    if (expected_dates.size() > 0) begin
      note_failure($sformatf("%0d results never arrived", expected_dates.size()));
    end

    $display("Converted %0d timestamps: %0d beyond the covered span, %0d on 29 February.",
             converted_count, beyond_span_count, leap_day_count);
    $display("Failures counted: %0d.", error_count);
    if (error_count == 0) begin
      $display("epoch_ms_to_calendar_fields: match");
    end else begin
      $display("epoch_ms_to_calendar_fields: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("Run timed out with %0d results outstanding.", expected_dates.size());
    $display("epoch_ms_to_calendar_fields: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
